/* hw/rtl/bdq_pkg.sv */
// Shared types, codes and sizing helpers for the bounded deque core.
package bdq_pkg;

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_PEEK_FRONT = 3'd4,
		MODE_PEEK_BACK  = 3'd5,
		MODE_CLEAR      = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEL_NONE  = 2'd0,
		SEL_FRONT = 2'd1,
		SEL_BACK  = 2'd2
	} sel_t;

	typedef struct packed {
		logic shr;
		logic shl;
		logic ld_back;
	} cell_ctl_t;

	localparam int unsigned TREE_FAN = 16;

	function automatic int unsigned tree_levels(int unsigned n);
		int unsigned p;
		int unsigned l;
		p = 1;
		l = 0;
		for (int k = 0; k < 32; k++) begin
			if (p < n) begin
				p = p * TREE_FAN;
				l = l + 1;
			end
		end
		return l;
	endfunction

endpackage

/* hw/rtl/bdq_cell.sv */
// One storage cell of the deque chain: shifts with its neighbors or loads a pushed value.
module bdq_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned VW  = 32,
	parameter int unsigned CW  = 11
) (
	input  logic              clk,
	input  bdq_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]     count,
	input  logic [VW-1:0]     push_data,
	input  logic [VW-1:0]     left_data,
	input  logic [VW-1:0]     right_data,
	output logic [VW-1:0]     data,
	output logic [VW-1:0]     tap
);
	import bdq_pkg::*;

	logic [VW-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.shr) begin
			data_q <= left_data;
		end else if (ctl.shl) begin
			data_q <= right_data;
		end else if (ctl.ld_back && (count == CW'(IDX))) begin
			data_q <= push_data;
		end
	end

	assign data = data_q;
	assign tap  = (count == CW'(IDX + 1)) ? data_q : '0;

endmodule

/* hw/rtl/bdq_or_tree.sv */
// Registered OR tree that gathers the tapped back entry from the cell row.
module bdq_or_tree #(
	parameter int unsigned W = 32,
	parameter int unsigned N = 1024
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);
	import bdq_pkg::*;

	localparam int unsigned LVLS  = tree_levels(N);
	localparam int unsigned PAD   = TREE_FAN ** LVLS;
	localparam int unsigned INNER = (PAD - 1) / (TREE_FAN - 1);
	localparam int unsigned TOTAL = INNER + PAD;

	logic [W-1:0] node [TOTAL];

	for (genvar i = 0; i < PAD; i++) begin : g_leaf
		if (i < N) begin : g_used
			assign node[INNER + i] = leaf[i];
		end else begin : g_pad
			assign node[INNER + i] = '0;
		end
	end

	for (genvar d = 1; d < LVLS; d++) begin : g_lvl
		for (genvar j = 0; j < TREE_FAN ** d; j++) begin : g_node
			localparam int unsigned ID = (TREE_FAN ** d - 1) / (TREE_FAN - 1) + j;
			logic [W-1:0] acc;
			always_comb begin
				acc = '0;
				for (int k = 0; k < TREE_FAN; k++) begin
					acc = acc | node[TREE_FAN * ID + 1 + k];
				end
			end
			always_ff @(posedge clk) begin
				node[ID] <= acc;
			end
		end
	end

	always_comb begin
		root = '0;
		for (int k = 0; k < TREE_FAN; k++) begin
			root = root | node[1 + k];
		end
	end

	assign node[0] = root;

endmodule

/* hw/rtl/bounded_deque_with_status_core.sv */
// Top level of the bounded deque: command decode, cell row, back-read tree and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  in      | in_valid / in_ready  | mode, push_value
//  out     | out_valid / out_ready| status, read_value, occupancy
//
// Every item waits while the registered OR tree reads the back entry out of the
// cell row; no new item is taken until that read has drained.
// The front entry always sits in cell 0; the back entry is the cell at count-1.
// Reset clears the count, the tree wait and the result valid; cells keep junk.
// in_ready drops while the tree drains and while a result beat is held by out_ready.
module bounded_deque_with_status_core #(
	parameter int unsigned DEPTH       = 1024,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] read_value,
	output logic [10:0]        occupancy
);
	import bdq_pkg::*;

	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned LAT = tree_levels(DEPTH) - 1;
	localparam int unsigned TW  = $clog2(LAT + 2);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_d;
	logic [TW-1:0]          wait_q;
	logic                   out_valid_q;
	status_t                status_q;
	status_t                status_d;
	sel_t                   sel_q;
	sel_t                   sel_d;
	logic [VALUE_WIDTH-1:0] front_q;
	logic [VALUE_WIDTH-1:0] back_q;
	logic [VALUE_WIDTH-1:0] root;
	logic [VALUE_WIDTH-1:0] wdata;
	logic [VALUE_WIDTH-1:0] data [DEPTH];
	logic [VALUE_WIDTH-1:0] tap  [DEPTH];
	cell_ctl_t              dec_ctl;
	cell_ctl_t              ctl;
	logic                   in_beat;
	logic                   done;

	assign in_ready = (wait_q == '0) && (!out_valid_q || out_ready);
	assign in_beat  = in_valid && in_ready;
	assign done     = (LAT == 0) ? in_beat : (wait_q == TW'(1));
	assign wdata    = VALUE_WIDTH'($unsigned(push_value));

	always_comb begin
		dec_ctl  = '0;
		count_d  = count_q;
		status_d = ST_OK;
		sel_d    = SEL_NONE;
		unique case (mode_t'(mode))
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (count_q == FULL_CNT) begin
					status_d = ST_FULL;
				end else begin
					dec_ctl.shr     = (mode == MODE_PUSH_FRONT);
					dec_ctl.ld_back = (mode == MODE_PUSH_BACK);
					count_d         = count_q + 1'b1;
				end
			end
			MODE_POP_FRONT, MODE_PEEK_FRONT: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					sel_d = SEL_FRONT;
					if (mode == MODE_POP_FRONT) begin
						dec_ctl.shl = 1'b1;
						count_d     = count_q - 1'b1;
					end
				end
			end
			MODE_POP_BACK, MODE_PEEK_BACK: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					sel_d = SEL_BACK;
					if (mode == MODE_POP_BACK) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign ctl = in_beat ? dec_ctl : '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_data;
		logic [VALUE_WIDTH-1:0] right_data;
		if (i == 0) begin : g_head
			assign left_data = wdata;
		end else begin : g_mid_l
			assign left_data = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_data = data[i];
		end else begin : g_mid_r
			assign right_data = data[i+1];
		end
		bdq_cell #(
			.IDX(i),
			.VW (VALUE_WIDTH),
			.CW (CW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.push_data (wdata),
			.left_data (left_data),
			.right_data(right_data),
			.data      (data[i]),
			.tap       (tap[i])
		);
	end

	bdq_or_tree #(
		.W(VALUE_WIDTH),
		.N(DEPTH)
	) u_tree (
		.clk (clk),
		.leaf(tap),
		.root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat) begin
				count_q <= count_d;
			end
			if (in_beat && (LAT != 0)) begin
				wait_q <= TW'(LAT);
			end else if (wait_q != '0) begin
				wait_q <= wait_q - 1'b1;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			status_q <= status_d;
			sel_q    <= sel_d;
			front_q  <= data[0];
		end
		if (done) begin
			back_q <= root;
		end
	end

	always_comb begin
		case (sel_q)
			SEL_FRONT: read_value = 32'($signed(front_q));
			SEL_BACK:  read_value = 32'($signed(back_q));
			default:   read_value = '0;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign occupancy = 11'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("count above depth");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(wait_q != '0) |-> !in_ready)
		else $error("input taken while back read drains");

	a_pop_front_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (mode == MODE_POP_FRONT) && (count_q != '0))
		|=> (count_q == $past(count_q) - 1'b1))
		else $error("pop front did not drop count");

	a_full_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && ((mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK))
		&& (count_q == FULL_CNT))
		|=> ((count_q == FULL_CNT) && (status_q == ST_FULL)))
		else $error("push into full store not refused");

	a_done_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("finished item did not raise result valid");

endmodule
